// ===== design/bud_pkg.sv =====
// Shared types, constants and helpers of the body unescape decoder.
`default_nettype none

package bud_pkg;

	// Sizing
	localparam int COUNT_BITS_DEF = 16;
	localparam int FQ_DEPTH       = 4;
	localparam int OQ_DEPTH       = 2;
	localparam int BUF_DEPTH      = 6;

	// Decode modes; any other code copies bytes as they are
	localparam logic [1:0] MODE_URL  = 2'd1;
	localparam logic [1:0] MODE_JSON = 2'd2;

	// Register select (paddr bit 2)
	localparam logic REG_IDX_MODE = 1'b0;
	localparam logic REG_IDX_CAP  = 1'b1;

	// Characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ESC_B  = 8'h62;
	localparam logic [7:0] CH_ESC_F  = 8'h66;
	localparam logic [7:0] CH_ESC_N  = 8'h6E;
	localparam logic [7:0] CH_ESC_R  = 8'h72;
	localparam logic [7:0] CH_ESC_T  = 8'h74;
	localparam logic [7:0] CH_ESC_U  = 8'h75;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_FF    = 8'h0C;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_TAB   = 8'h09;

	// UTF-8 encoding
	localparam logic [15:0] CP_MAX1   = 16'h007F;
	localparam logic [15:0] CP_MAX2   = 16'h07FF;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;

	// What the decode engine does with the head of its buffer
	typedef enum logic [1:0] {
		ACT_NEED,
		ACT_EMIT,
		ACT_UTF
	} act_t;

	// A body byte with its hex digit classification
	typedef struct packed {
		logic [7:0] data;
		logic       hex_ok;
		logic [3:0] hex_val;
	} sym_t;

	typedef struct packed {
		sym_t sym;
		logic last;
	} qent_t;

	// Front queue head toward the decode engine
	typedef struct packed {
		logic  valid;
		qent_t ent;
	} fq_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        end_of_body;
		logic [15:0] out_count;
	} result_t;

	// Decode engine push toward the output queue
	typedef struct packed {
		logic    valid;
		result_t res;
	} oq_push_t;

	function automatic sym_t hex_classify(input logic [7:0] b);
		sym_t s;
		s.data    = b;
		s.hex_ok  = 1'b1;
		s.hex_val = 4'd0;
		if (b inside {[CH_0:CH_9]}) begin
			s.hex_val = 4'(b - CH_0);
		end else if (b inside {[CH_LOW_A:CH_LOW_F]}) begin
			s.hex_val = 4'(b - CH_LOW_A + 8'd10);
		end else if (b inside {[CH_UP_A:CH_UP_F]}) begin
			s.hex_val = 4'(b - CH_UP_A + 8'd10);
		end else begin
			s.hex_ok = 1'b0;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== design/bud_front.sv =====
// Input side: accepts body bytes, tags hex digits and queues them for decode.
`default_nettype none

module bud_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // [7:0] in_byte
	input  wire logic          s_tlast,
	output bud_pkg::fq_t       fq,
	input  wire logic          fq_pop
);
	import bud_pkg::*;

	localparam int AW = $clog2(FQ_DEPTH);

	qent_t         mem_q [FQ_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign s_tready = cnt_q < (AW+1)'(FQ_DEPTH);
	assign push     = s_tvalid && s_tready;
	assign pop      = fq_pop && (cnt_q != '0);

	assign fq.valid = cnt_q != '0;
	assign fq.ent   = mem_q[rd_q];

	// Queue storage, classified on the way in
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{sym: hex_classify(s_tdata), last: s_tlast};
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/bud_back.sv =====
// Decode engine: lookahead buffer, escape resolution, UTF-8 output, capacity.
`default_nettype none

module bud_back #(
	parameter int COUNT_BITS = bud_pkg::COUNT_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     decode_mode,
	input  wire logic [15:0]    out_capacity,
	input  wire bud_pkg::fq_t   fq,
	output logic                fq_pop,
	input  wire logic           room,
	output bud_pkg::oq_push_t   oq
);
	import bud_pkg::*;

	localparam int CMPW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

	// Engine state
	sym_t                  buf_q [BUF_DEPTH];
	logic [2:0]            cnt_q;
	logic                  active_q;
	logic                  last_q;
	logic [1:0]            sub_q;
	logic [COUNT_BITS-1:0] ecnt_q;
	logic                  stop_q;
	result_t               hold_q;
	logic                  hold_vld_q;

	sym_t                  buf_d [BUF_DEPTH];
	logic [2:0]            cnt_d;
	logic                  active_d;
	logic                  last_d;
	logic [1:0]            sub_d;
	logic [COUNT_BITS-1:0] ecnt_d;
	logic                  stop_d;
	result_t               hold_d;
	logic                  hold_vld_d;

	// Working view
	logic       take;
	sym_t       w [BUF_DEPTH];
	sym_t       sh [BUF_DEPTH];
	logic [2:0] wcnt;
	logic       wlast;

	// Head decode
	act_t       act;
	logic [7:0] ebyte;
	logic [2:0] used;
	logic [2:0] rem;
	logic [15:0] cp;
	logic       url_bad;
	logic       u_bad;
	logic       len2;
	logic [1:0] ulen;
	logic [7:0] ubyte;
	logic       u_final;

	// Capacity
	logic [CMPW-1:0] cnt_w;
	logic [CMPW-1:0] inc_w;
	logic [CMPW-1:0] cap_w;
	logic [CMPW-1:0] mask_w;
	logic [CMPW-1:0] eff_w;
	logic            fits_one;
	logic            fits_utf;

	logic    finalize;
	logic    do_emit;
	logic    do_stop;
	logic    do_consume;
	logic [7:0] rb;
	result_t res;

	assign take   = fq.valid && !active_q && room;
	assign fq_pop = take;

	// Buffer with the incoming byte appended
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) w[i] = buf_q[i];
		wcnt  = cnt_q;
		wlast = last_q;
		if (take) begin
			w[cnt_q] = fq.ent.sym;
			wcnt     = cnt_q + 3'd1;
			wlast    = fq.ent.last;
		end
	end

	// Classify the unit at the head of the buffer
	always_comb begin
		act     = ACT_EMIT;
		ebyte   = w[0].data;
		used    = 3'd1;
		cp      = {w[2].hex_val, w[3].hex_val, w[4].hex_val, w[5].hex_val};
		url_bad = (wcnt > 3'd1 && !w[1].hex_ok) || (wcnt > 3'd2 && !w[2].hex_ok);
		u_bad   = (wcnt > 3'd2 && !w[2].hex_ok) || (wcnt > 3'd3 && !w[3].hex_ok) ||
		          (wcnt > 3'd4 && !w[4].hex_ok) || (wcnt > 3'd5 && !w[5].hex_ok);
		case (decode_mode)
			MODE_URL: begin
				if (w[0].data == CH_PLUS) begin
					ebyte = CH_SPACE;
				end else if (w[0].data == CH_PCT && !url_bad) begin
					if (wcnt < 3'd3) begin
						if (!wlast) act = ACT_NEED;
					end else begin
						ebyte = {w[1].hex_val, w[2].hex_val};
						used  = 3'd3;
					end
				end
			end
			MODE_JSON: begin
				if (w[0].data == CH_BSL) begin
					if (wcnt < 3'd2) begin
						if (!wlast) act = ACT_NEED;
					end else begin
						case (w[1].data)
							CH_QUOTE: begin ebyte = CH_QUOTE; used = 3'd2; end
							CH_BSL:   begin ebyte = CH_BSL;   used = 3'd2; end
							CH_SLASH: begin ebyte = CH_SLASH; used = 3'd2; end
							CH_ESC_B: begin ebyte = CTL_BS;   used = 3'd2; end
							CH_ESC_F: begin ebyte = CTL_FF;   used = 3'd2; end
							CH_ESC_N: begin ebyte = CTL_LF;   used = 3'd2; end
							CH_ESC_R: begin ebyte = CTL_CR;   used = 3'd2; end
							CH_ESC_T: begin ebyte = CTL_TAB;  used = 3'd2; end
							CH_ESC_U: begin
								if (!u_bad) begin
									if (wcnt < 3'd6) begin
										if (!wlast) act = ACT_NEED;
									end else begin
										used = 3'd6;
										if (cp <= CP_MAX1) ebyte = cp[7:0];
										else act = ACT_UTF;
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	// UTF-8 byte for the current sub step
	always_comb begin
		len2    = cp <= CP_MAX2;
		ulen    = len2 ? 2'd2 : 2'd3;
		u_final = sub_q == (ulen - 2'd1);
		case (sub_q)
			2'd0:    ubyte = len2 ? (UTF_LEAD2 | {3'b000, cp[10:6]})
			                      : (UTF_LEAD3 | {4'b0000, cp[15:12]});
			2'd1:    ubyte = len2 ? (UTF_CONT | {2'b00, cp[5:0]})
			                      : (UTF_CONT | {2'b00, cp[11:6]});
			default: ubyte = UTF_CONT | {2'b00, cp[5:0]};
		endcase
	end

	// Effective capacity limited by the counter width
	always_comb begin
		cnt_w    = CMPW'(ecnt_q);
		inc_w    = cnt_w + CMPW'(1);
		cap_w    = CMPW'(out_capacity);
		mask_w   = CMPW'({COUNT_BITS{1'b1}});
		eff_w    = (cap_w < mask_w) ? cap_w : mask_w;
		fits_one = cnt_w < eff_w;
		fits_utf = (cnt_w + CMPW'(ulen)) <= eff_w;
	end

	// Buffer after dropping the consumed unit
	assign rem = wcnt - used;
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) sh[i] = w[i];
		case (used)
			3'd1:    for (int i = 0; i < BUF_DEPTH - 1; i++) sh[i] = w[i + 1];
			3'd2:    for (int i = 0; i < BUF_DEPTH - 2; i++) sh[i] = w[i + 2];
			3'd3:    for (int i = 0; i < BUF_DEPTH - 3; i++) sh[i] = w[i + 3];
			default: ;
		endcase
	end

	// Next state and result push
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) buf_d[i] = buf_q[i];
		cnt_d      = cnt_q;
		active_d   = active_q;
		last_d     = last_q;
		sub_d      = sub_q;
		ecnt_d     = ecnt_q;
		stop_d     = stop_q;
		hold_d     = hold_q;
		hold_vld_d = hold_vld_q;
		oq.valid   = 1'b0;
		oq.res     = hold_q;
		do_emit    = 1'b0;
		do_stop    = 1'b0;
		do_consume = 1'b0;
		rb         = ebyte;
		res        = '{out_byte: rb, byte_valid: 1'b1, end_of_body: 1'b0,
		               out_count: inc_w[15:0]};
		finalize   = active_q && last_q && (cnt_q == 3'd0 || stop_q);

		if (room && finalize) begin
			// End of body: tag the last result of this beat or send a bare marker
			oq.valid = 1'b1;
			if (hold_vld_q) begin
				oq.res = hold_q;
			end else begin
				oq.res = '{out_byte: 8'd0, byte_valid: 1'b0, end_of_body: 1'b0,
				           out_count: cnt_w[15:0]};
			end
			oq.res.end_of_body = 1'b1;
			cnt_d      = 3'd0;
			active_d   = 1'b0;
			last_d     = 1'b0;
			sub_d      = 2'd0;
			ecnt_d     = '0;
			stop_d     = 1'b0;
			hold_vld_d = 1'b0;
		end else if (room && (active_q || take)) begin
			last_d = wlast;
			if (stop_q) begin
				// Output already stopped: drop everything of this body
				cnt_d    = 3'd0;
				active_d = wlast;
			end else begin
				case (act)
					ACT_EMIT: begin
						if (fits_one) begin
							do_emit    = 1'b1;
							do_consume = 1'b1;
						end else begin
							do_stop = 1'b1;
						end
					end
					ACT_UTF: begin
						if (sub_q == 2'd0 && !fits_utf) begin
							do_stop = 1'b1;
						end else begin
							do_emit = 1'b1;
							rb      = ubyte;
							if (u_final) do_consume = 1'b1;
							else sub_d = sub_q + 2'd1;
						end
					end
					default: ;
				endcase

				res.out_byte = rb;
				if (do_stop) begin
					stop_d   = 1'b1;
					cnt_d    = 3'd0;
					sub_d    = 2'd0;
					active_d = wlast;
				end else if (do_consume) begin
					for (int i = 0; i < BUF_DEPTH; i++) buf_d[i] = sh[i];
					cnt_d    = rem;
					sub_d    = 2'd0;
					active_d = wlast || (rem != 3'd0);
				end else begin
					for (int i = 0; i < BUF_DEPTH; i++) buf_d[i] = w[i];
					cnt_d    = wcnt;
					active_d = wlast || (act != ACT_NEED);
				end

				if (do_emit) begin
					ecnt_d = ecnt_q + 1'b1;
					if (wlast) begin
						// Final beat of a body: keep the newest result back
						oq.valid   = hold_vld_q;
						oq.res     = hold_q;
						hold_d     = res;
						hold_vld_d = 1'b1;
					end else begin
						oq.valid = 1'b1;
						oq.res   = res;
					end
				end
			end
		end
	end

	// Lookahead and hold payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < BUF_DEPTH; i++) buf_q[i] <= buf_d[i];
		hold_q <= hold_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 3'd0;
			active_q   <= 1'b0;
			last_q     <= 1'b0;
			sub_q      <= 2'd0;
			ecnt_q     <= '0;
			stop_q     <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			cnt_q      <= cnt_d;
			active_q   <= active_d;
			last_q     <= last_d;
			sub_q      <= sub_d;
			ecnt_q     <= ecnt_d;
			stop_q     <= stop_d;
			hold_vld_q <= hold_vld_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/bud_outq.sv =====
// Output side: small result queue that decouples the engine from the sink.
`default_nettype none

module bud_outq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bud_pkg::oq_push_t  oq,
	output logic                    room,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [23:0]             m_tdata,  // [7:0] out_byte, [23:8] out_count
	output logic                    m_tuser,  // [0] byte_valid
	output logic                    m_tlast
);
	import bud_pkg::*;

	localparam int AW = $clog2(OQ_DEPTH);

	result_t       mem_q [OQ_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	result_t       head;
	logic          push;
	logic          pop;

	assign room     = cnt_q < (AW+1)'(OQ_DEPTH);
	assign push     = oq.valid && room;
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;

	assign head    = mem_q[rd_q];
	assign m_tdata = {head.out_count, head.out_byte};
	assign m_tuser = head.byte_valid;
	assign m_tlast = head.end_of_body;

	// Result storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= oq.res;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/body_unescape_decoder.sv =====
// Top level of the body unescape decoder: config registers and the three stages.
// Streams body bytes and returns decoded bytes in raw, URL-form or JSON-string
// mode, selected by the decode_mode register; at most out_capacity bytes are sent
// per body, and each body closes with a beat carrying tlast (a bare marker with
// tuser low when the final byte yields no data). Plain bytes and the byte that
// completes an escape go through at one per cycle while the output queue has room.
// A byte held as lookahead for an escape sends nothing; a \u escape that encodes
// to two or three UTF-8 bytes sends them one after another, and the bytes after
// a bad or cut-off escape are rescanned. The end beat of a body follows the
// decode of its final byte. The decode engine sets the pace: it resolves one
// escape unit or sends one output byte per cycle while the output queue has room;
// a four-entry input queue and a two-entry output queue absorb stalls on either
// side. The first result of an input beat passes the input and output queues.
`default_nettype none

module body_unescape_decoder #(
	parameter int COUNT_BITS = bud_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Body byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	// Decoded stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_count
	output logic             m_tuser,   // [0] byte_valid
	output logic             m_tlast,
	// Register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import bud_pkg::*;

	logic [1:0]  mode_q;
	logic [15:0] cap_q;
	logic        wr_en;
	fq_t         fq;
	logic        fq_pop;
	oq_push_t    oq;
	logic        room;

	// Registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			cap_q  <= 16'hFFFF;
		end else if (wr_en) begin
			case (paddr[2])
				REG_IDX_MODE: mode_q <= pwdata[1:0];
				REG_IDX_CAP:  cap_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IDX_MODE: prdata = {30'd0, mode_q};
			REG_IDX_CAP:  prdata = {16'd0, cap_q};
			default:      prdata = 32'd0;
		endcase
	end

	bud_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.fq       (fq),
		.fq_pop   (fq_pop)
	);

	bud_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.decode_mode  (mode_q),
		.out_capacity (cap_q),
		.fq           (fq),
		.fq_pop       (fq_pop),
		.room         (room),
		.oq           (oq)
	);

	bud_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.oq       (oq),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== design/bud_checker.sv =====
// Port-level checks on the decoded stream, bound to the top level.
`default_nettype none

module bud_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// A stalled beat stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output beat changed while stalled");

	// A beat without data only ever closes a body
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("bare marker without end of body");

	// A bare marker carries a zero byte
	a_bare_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("bare marker with nonzero byte");

	// A data beat counts itself
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[23:8] != 16'd0)
		else $error("data beat with zero count");

endmodule

bind body_unescape_decoder bud_checker u_bud_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/unescape_checker.sv =====
`timescale 1ns / 1ps
// Checker for the body unescape decoder: tracks registers, predicts decoded beats, compares.
module unescape_checker
	import bud_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_count
	input  logic        m_tuser,   // [0] byte_valid
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          err_count,
	output int          exp_left
);

	localparam int ERR_PRINT_MAX = 40;

	// Register shadows and decoder state
	logic [1:0]  cur_mode;
	logic [15:0] cur_cap;
	logic [7:0]  held [0:4];
	int          held_n;
	int          sent_n;
	bit          halted;
	logic [7:0]  scan [0:5];
	int          errs;

	// Decoded beats still owed by the block, oldest first
	result_t     decoded_q[$];

	function automatic int hex_digit(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c - CH_0);
		if (c >= CH_LOW_A && c <= CH_LOW_F)
			return int'(c - CH_LOW_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F)
			return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	// One data byte, unless the body is over its capacity
	function automatic void put_byte(logic [7:0] b);
		result_t r;
		if (halted || sent_n >= int'(cur_cap)) begin
			halted = 1'b1;
			return;
		end
		sent_n++;
		r.out_byte    = b;
		r.byte_valid  = 1'b1;
		r.end_of_body = 1'b0;
		r.out_count   = 16'(sent_n);
		decoded_q.push_back(r);
	endfunction

	// Code point to UTF-8; a sequence that does not fit stops the body
	function automatic void put_utf8(int cp);
		int len;
		if (cp <= int'(CP_MAX1)) begin
			put_byte(8'(cp));
			return;
		end
		len = (cp <= int'(CP_MAX2)) ? 2 : 3;
		if (halted || sent_n + len > int'(cur_cap)) begin
			halted = 1'b1;
			return;
		end
		if (len == 2) begin
			put_byte(UTF_LEAD2 | 8'((cp >> 6) & 'h1F));
			put_byte(UTF_CONT | 8'(cp & 'h3F));
		end else begin
			put_byte(UTF_LEAD3 | 8'((cp >> 12) & 'h0F));
			put_byte(UTF_CONT | 8'((cp >> 6) & 'h3F));
			put_byte(UTF_CONT | 8'(cp & 'h3F));
		end
	endfunction

	// URL unit at scan[p]; bytes used, 0 when more lookahead is needed
	function automatic int url_unit(int p, int n, bit last);
		int k;
		if (scan[p] == CH_PLUS) begin
			put_byte(CH_SPACE);
			return 1;
		end
		if (scan[p] != CH_PCT) begin
			put_byte(scan[p]);
			return 1;
		end
		for (k = 1; k < n - p && k < 3; k++) begin
			if (hex_digit(scan[p + k]) < 0) begin
				put_byte(CH_PCT);
				return 1;
			end
		end
		if (n - p < 3) begin
			if (last) begin
				put_byte(CH_PCT);
				return 1;
			end
			return 0;
		end
		put_byte(8'((hex_digit(scan[p + 1]) << 4) | hex_digit(scan[p + 2])));
		return 3;
	endfunction

	// JSON unit at scan[p]; same contract as url_unit
	function automatic int json_unit(int p, int n, bit last);
		int         k;
		int         cp;
		logic [7:0] c;
		if (scan[p] != CH_BSL) begin
			put_byte(scan[p]);
			return 1;
		end
		if (n - p < 2) begin
			if (last) begin
				put_byte(CH_BSL);
				return 1;
			end
			return 0;
		end
		case (scan[p + 1])
			CH_QUOTE, CH_BSL, CH_SLASH: c = scan[p + 1];
			CH_ESC_B: c = CTL_BS;
			CH_ESC_F: c = CTL_FF;
			CH_ESC_N: c = CTL_LF;
			CH_ESC_R: c = CTL_CR;
			CH_ESC_T: c = CTL_TAB;
			CH_ESC_U: begin
				// bad hex is decided as soon as it is seen
				for (k = 2; k < n - p && k < 6; k++) begin
					if (hex_digit(scan[p + k]) < 0) begin
						put_byte(CH_BSL);
						return 1;
					end
				end
				if (n - p < 6) begin
					if (last) begin
						put_byte(CH_BSL);
						return 1;
					end
					return 0;
				end
				cp = 0;
				for (k = 2; k < 6; k++)
					cp = (cp << 4) | hex_digit(scan[p + k]);
				put_utf8(cp);
				return 6;
			end
			default: begin
				put_byte(CH_BSL);
				return 1;
			end
		endcase
		put_byte(c);
		return 2;
	endfunction

	// Decode one accepted input beat into expected output beats
	task automatic predict_beat(logic [7:0] b, bit last);
		int      n;
		int      p;
		int      k;
		int      used;
		int      q_base;
		result_t r;
		n = held_n;
		for (k = 0; k < n; k++)
			scan[k] = held[k];
		scan[n] = b;
		n++;
		q_base = decoded_q.size();
		p = 0;
		while (p < n && !halted) begin
			case (cur_mode)
				MODE_URL:  used = url_unit(p, n, last);
				MODE_JSON: used = json_unit(p, n, last);
				default: begin
					put_byte(scan[p]);
					used = 1;
				end
			endcase
			if (used == 0)
				break;
			p += used;
		end
		if (halted)
			p = n;
		held_n = n - p;
		for (k = 0; k < held_n; k++)
			held[k] = scan[p + k];
		// body end: tag the last beat, or send a bare marker
		if (last) begin
			if (decoded_q.size() == q_base) begin
				r.out_byte    = 8'h00;
				r.byte_valid  = 1'b0;
				r.end_of_body = 1'b0;
				r.out_count   = 16'(sent_n);
				decoded_q.push_back(r);
			end
			r = decoded_q.pop_back();
			r.end_of_body = 1'b1;
			decoded_q.push_back(r);
			held_n = 0;
			sent_n = 0;
			halted = 1'b0;
		end
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errs++;
			if (errs <= ERR_PRINT_MAX)
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
		end
	endfunction

	task automatic check_beat();
		result_t want;
		if (decoded_q.size() == 0) begin
			errs++;
			if (errs <= ERR_PRINT_MAX)
				$error("unexpected output beat: out_byte 0x%0h out_count %0d",
					m_tdata[7:0], m_tdata[23:8]);
			return;
		end
		want = decoded_q.pop_front();
		check_field("out_byte", want.out_byte, m_tdata[7:0]);
		check_field("byte_valid", want.byte_valid, m_tuser);
		check_field("end_of_body", want.end_of_body, m_tlast);
		check_field("out_count", want.out_count, m_tdata[23:8]);
	endtask

	// Output beat first, then register writes, then the new input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = 2'd0;
			cur_cap  = 16'hFFFF;
			held_n   = 0;
			sent_n   = 0;
			halted   = 1'b0;
			errs     = 0;
			decoded_q.delete();
			err_count <= 0;
			exp_left  <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IDX_CAP)
					cur_cap = pwdata[15:0];
				else
					cur_mode = pwdata[1:0];
			end
			if (s_tvalid && s_tready)
				predict_beat(s_tdata, s_tlast);
			err_count <= errs;
			exp_left  <= decoded_q.size();
		end
	end

endmodule

// ===== verif/tb_body_unescape_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the body unescape decoder: clock, reset, stimulus and verdict.
module tb_body_unescape_decoder;
	import bud_pkg::*;

	localparam int         SETTLE_CYCLES   = 8;
	localparam int         DRAIN_CYCLES    = 20;
	localparam int         WATCHDOG_LIMIT  = 5000;
	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         RANDOM_ITEMS    = 300;
	localparam int         QUIET_TAIL      = 60;
	localparam logic [1:0] MODE_RAW        = 2'd0;
	localparam logic [1:0] MODE_RAW_ALT    = 2'd3;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] out_count
	logic        m_tuser;   // [0] byte_valid
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          err_count;
	int          exp_left;
	int          items_sent;
	int          stall_cycles;
	bit          idle_on;
	bit          hold_off_req;
	byte_q_t     body_buf;

	body_unescape_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	unescape_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.err_count (err_count),
		.exp_left  (exp_left)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: cycles with no beat on either stream and no register access
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random ready bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(0, idle_on ? 15 : 0)) @(posedge clk);
			end
		end
	end

	// Two-phase register write
	task automatic apb_write(logic idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [1:0] mode, logic [15:0] cap);
		apb_write(REG_IDX_MODE, {30'd0, mode});
		apb_write(REG_IDX_CAP, {16'd0, cap});
	endtask

	// One input beat, optionally after a random gap
	task automatic send_byte(logic [7:0] b, bit last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_body(byte_q_t body, bit close);
		int i;
		for (i = 0; i < body.size(); i++)
			send_byte(body[i], close && (i == body.size() - 1));
	endtask

	// Stop offering, wait out every expected beat, then let held bytes settle
	task automatic quiesce();
		s_tvalid <= 1'b0;
		// wait for the count of the last accepted beat to show up in exp_left
		@(posedge clk);
		while (exp_left != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10)
			c = CH_0 + 8'(v);
		else if ($urandom_range(0, 1) == 1)
			c = CH_LOW_A + 8'(v - 4'd10);
		else
			c = CH_UP_A + 8'(v - 4'd10);
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		c = 8'($urandom);
		while (c inside {[CH_0:CH_9], [CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]})
			c = 8'($urandom);
		return c;
	endfunction

	function automatic logic [7:0] simple_esc();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = CH_QUOTE;
			1: c = CH_BSL;
			2: c = CH_SLASH;
			3: c = CH_ESC_B;
			4: c = CH_ESC_F;
			5: c = CH_ESC_N;
			6: c = CH_ESC_R;
			default: c = CH_ESC_T;
		endcase
		return c;
	endfunction

	// Append one mostly well-formed token for the given mode to body_buf
	task automatic add_token(logic [1:0] mode);
		int          pick;
		int          k;
		int          n_good;
		logic [15:0] cp;
		pick = $urandom_range(0, 9);
		case (mode)
			MODE_URL: begin
				if (pick < 3) begin
					body_buf.push_back(8'($urandom));
				end else if (pick < 4) begin
					body_buf.push_back(CH_PLUS);
				end else if (pick < 8) begin
					cp = 16'($urandom);
					body_buf.push_back(CH_PCT);
					body_buf.push_back(hex_char(cp[7:4]));
					body_buf.push_back(hex_char(cp[3:0]));
				end else begin
					// broken escape: bad digit in first or second place
					body_buf.push_back(CH_PCT);
					if ($urandom_range(0, 1) == 1)
						body_buf.push_back(hex_char(4'($urandom)));
					body_buf.push_back(non_hex_char());
				end
			end
			MODE_JSON: begin
				if (pick < 3) begin
					body_buf.push_back(8'($urandom));
				end else if (pick < 5) begin
					body_buf.push_back(CH_BSL);
					body_buf.push_back(simple_esc());
				end else if (pick < 8) begin
					case ($urandom_range(0, 3))
						0: cp = 16'($urandom_range(0, 'h7F));
						1: cp = 16'($urandom_range('h80, 'h7FF));
						2: cp = 16'($urandom_range('h800, 'hFFFF));
						default: cp = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
					endcase
					body_buf.push_back(CH_BSL);
					body_buf.push_back(CH_ESC_U);
					for (k = 3; k >= 0; k--)
						body_buf.push_back(hex_char(cp[k*4 +: 4]));
				end else if (pick < 9) begin
					// \u with a bad digit somewhere in the four
					n_good = $urandom_range(0, 3);
					body_buf.push_back(CH_BSL);
					body_buf.push_back(CH_ESC_U);
					for (k = 0; k < n_good; k++)
						body_buf.push_back(hex_char(4'($urandom)));
					body_buf.push_back(non_hex_char());
				end else begin
					body_buf.push_back(CH_BSL);
					body_buf.push_back(8'($urandom));
				end
			end
			default: begin
				if (pick < 2)
					body_buf.push_back(($urandom_range(0, 1) == 1) ? CH_PCT : CH_BSL);
				else
					body_buf.push_back(8'($urandom));
			end
		endcase
	endtask

	// A random body; now and then its tail is cut to leave an escape open
	task automatic send_random_body(logic [1:0] mode);
		int t;
		int n_tok;
		body_buf.delete();
		n_tok = $urandom_range(1, 6);
		for (t = 0; t < n_tok; t++)
			add_token(mode);
		if ($urandom_range(0, 5) == 0) begin
			t = $urandom_range(1, 3);
			while (t > 0 && body_buf.size() > 1) begin
				void'(body_buf.pop_back());
				t--;
			end
		end
		send_body(body_buf, 1'b1);
	endtask

	initial begin
		int          random_goal;
		int          phase;
		int          n_body;
		int          b;
		logic [1:0]  mode;
		logic [15:0] cap;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = 3'd0;
		pwdata       = 32'd0;
		items_sent   = 0;
		stall_cycles = 0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Raw copy of the byte extremes
		set_config(MODE_RAW, 16'hFFFF);
		send_body('{8'h00, 8'hFF}, 1'b1);
		quiesce();

		// URL: plus, valid hex, bad hex, then a cut-off percent
		set_config(MODE_URL, 16'hFFFF);
		send_body('{CH_PLUS, CH_PCT, "4", "1", CH_PCT, "z"}, 1'b1);
		send_body('{CH_PCT}, 1'b1);
		quiesce();

		// JSON: simple escape and the largest two-byte code point
		set_config(MODE_JSON, 16'hFFFF);
		send_body('{CH_BSL, CH_ESC_T, CH_BSL, CH_ESC_U, "0", "7", "F", "F"}, 1'b1);
		quiesce();

		// JSON: three-byte sequence over capacity, body ends with a bare marker
		set_config(MODE_JSON, 16'd2);
		send_body('{CH_BSL, CH_ESC_U, "2", "0", "A", "C"}, 1'b1);
		quiesce();

		// Mode changes while a percent is held as lookahead
		set_config(MODE_URL, 16'hFFFF);
		send_byte(CH_PCT, 1'b0);
		quiesce();
		apb_write(REG_IDX_MODE, {30'd0, MODE_JSON});
		send_byte("x", 1'b1);
		quiesce();

		// Mode three copies raw; zero capacity drops everything
		set_config(MODE_RAW_ALT, 16'd0);
		send_body('{"A"}, 1'b1);
		quiesce();

		// Random phases, each with its own settings
		random_goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < random_goal) begin
			phase++;
			case ($urandom_range(0, 9))
				0:       mode = MODE_RAW;
				1:       mode = MODE_RAW_ALT;
				2, 3, 4, 5: mode = MODE_URL;
				default: mode = MODE_JSON;
			endcase
			case ($urandom_range(0, 9))
				0:          cap = 16'd0;
				1, 2, 3, 4: cap = 16'($urandom_range(1, 12));
				5:          cap = 16'($urandom);
				default:    cap = 16'hFFFF;
			endcase
			if (items_sent >= random_goal - QUIET_TAIL)
				idle_on = 1'b0;
			set_config(mode, cap);
			n_body = $urandom_range(2, 6);
			// one phase backs up the output so the input side stalls
			if (phase == 2) begin
				hold_off_req = 1'b1;
				n_body = 10;
			end
			for (b = 0; b < n_body; b++)
				send_random_body(mode);
			quiesce();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && exp_left == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
